// ----- hw/rtl/pdir_pkg.sv -----
// shared types, constants and helpers for the pulse distance ir frame sender
`timescale 1ns / 1ps
`default_nettype none
package pdir_pkg;

    localparam int FRAME_BITS = 16;
    localparam int BITS_W     = $clog2(FRAME_BITS + 1);
    localparam int RAW_W      = 16;
    localparam int CFG_DATA_W = 18;
    localparam int CFG_IDX_W  = 3;
    localparam int SEG_W      = 12;
    localparam int SINCE_W    = 18;
    localparam int STEP_W     = 16;
    localparam int FRAMES_W   = 3;

    localparam logic [SINCE_W-1:0] SINCE_MAX = {SINCE_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_NIBBLE = 2'd1,
        CMD_RAW    = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ONE_SPACE    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_REPEAT_BASE  = 3'd5,
        REG_REPEAT_STEP  = 3'd6,
        REG_REPEAT_COUNT = 3'd7
    } reg_idx_t;

    localparam logic [SEG_W-1:0]    HEADER_MARK_RST  = 12'd158;
    localparam logic [SEG_W-1:0]    HEADER_SPACE_RST = 12'd1026;
    localparam logic [SEG_W-1:0]    BIT_MARK_RST     = 12'd158;
    localparam logic [SEG_W-1:0]    ONE_SPACE_RST    = 12'd553;
    localparam logic [SEG_W-1:0]    ZERO_SPACE_RST   = 12'd263;
    localparam logic [SINCE_W-1:0]  REPEAT_BASE_RST  = 18'd110000;
    localparam logic [STEP_W-1:0]   REPEAT_STEP_RST  = 16'd40000;
    localparam logic [FRAMES_W-1:0] REPEAT_COUNT_RST = 3'd5;

    typedef struct packed {
        logic [SEG_W-1:0]    header_mark_us;
        logic [SEG_W-1:0]    header_space_us;
        logic [SEG_W-1:0]    bit_mark_us;
        logic [SEG_W-1:0]    one_space_us;
        logic [SEG_W-1:0]    zero_space_us;
        logic [SINCE_W-1:0]  repeat_base_us;
        logic [STEP_W-1:0]   repeat_step_us;
        logic [FRAMES_W-1:0] repeat_frames;
    } cfg_t;

    typedef struct packed {
        logic [FRAME_BITS-1:0] frame;
        logic [SINCE_W-1:0]    period;
        logic [FRAMES_W-1:0]   frames;
    } load_t;

    // zero-extend or truncate a 16-bit frame to the shifter width
    function automatic logic [FRAME_BITS-1:0] fit_frame(input logic [RAW_W-1:0] f);
        logic [FRAME_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            if (i < RAW_W)
            begin
                r[i] = f[i];
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/pdir_cmd_if.sv -----
// command channel interface of the pulse distance ir frame sender
`timescale 1ns / 1ps
`default_nettype none
interface pdir_cmd_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [3:0] channel_nibble;
    logic [3:0] mode_nibble;
    logic [3:0] command_nibble;
    logic [15:0] raw_frame;
    logic       repeat_request;

    modport source (
        output valid, cmd, channel_nibble, mode_nibble, command_nibble, raw_frame,
               repeat_request,
        input  ready
    );
    modport sink (
        input  valid, cmd, channel_nibble, mode_nibble, command_nibble, raw_frame,
               repeat_request,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/pdir_res_if.sv -----
// result channel interface of the pulse distance ir frame sender
`timescale 1ns / 1ps
`default_nettype none
interface pdir_res_if;
    logic valid;
    logic ready;
    logic ir_on;
    logic busy_res;
    logic rejected;

    modport source (
        output valid, ir_on, busy_res, rejected,
        input  ready
    );
    modport sink (
        input  valid, ir_on, busy_res, rejected,
        output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/pulse_distance_ir_frame_sender.sv -----
// top level of the pulse distance ir frame sender
`timescale 1ns / 1ps
`default_nettype none
// Pulse-distance infrared frame sender. Each command transfer yields exactly one result
// transfer. A tick command advances the carrier envelope by one microsecond and reports
// ir_on for that microsecond; a send command (three nibbles with computed parity, or a
// raw 16-bit frame) loads the frame when idle and is flagged in rejected when busy.
// One command is taken per clock cycle: the sequencer updates its state and the result
// register in the same cycle, so a result is registered in the cycle after its command transfer,
// and a new command is taken whenever the result register is empty or being drained.
// Write configuration registers via cfg_we/cfg_idx/cfg_wdata only while idle (unchecked).
module pulse_distance_ir_frame_sender (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [pdir_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [pdir_pkg::CFG_DATA_W-1:0] cfg_wdata,
    pdir_cmd_if.sink                             cmd_ch,
    pdir_res_if.source                           res_ch
);

    pdir_pkg::cfg_t  cfg;
    pdir_pkg::load_t load;
    logic            accept;

    assign cmd_ch.ready = !res_ch.valid || res_ch.ready;
    assign accept       = cmd_ch.valid && cmd_ch.ready;

    pdir_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    pdir_frame_build u_frame_build (
        .cmd            (cmd_ch.cmd),
        .channel_nibble (cmd_ch.channel_nibble),
        .mode_nibble    (cmd_ch.mode_nibble),
        .command_nibble (cmd_ch.command_nibble),
        .raw_frame      (cmd_ch.raw_frame),
        .repeat_request (cmd_ch.repeat_request),
        .cfg            (cfg),
        .load           (load)
    );

    pdir_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .cmd       (cmd_ch.cmd),
        .load      (load),
        .cfg       (cfg),
        .out_ready (res_ch.ready),
        .out_valid (res_ch.valid),
        .ir_on     (res_ch.ir_on),
        .busy_res  (res_ch.busy_res),
        .rejected  (res_ch.rejected)
    );

endmodule
`default_nettype wire

// ----- hw/rtl/pdir_cfg_regs.sv -----
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none
module pdir_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [pdir_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [pdir_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output pdir_pkg::cfg_t                     cfg
);

    pdir_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark_us  <= pdir_pkg::HEADER_MARK_RST;
            cfg_reg.header_space_us <= pdir_pkg::HEADER_SPACE_RST;
            cfg_reg.bit_mark_us     <= pdir_pkg::BIT_MARK_RST;
            cfg_reg.one_space_us    <= pdir_pkg::ONE_SPACE_RST;
            cfg_reg.zero_space_us   <= pdir_pkg::ZERO_SPACE_RST;
            cfg_reg.repeat_base_us  <= pdir_pkg::REPEAT_BASE_RST;
            cfg_reg.repeat_step_us  <= pdir_pkg::REPEAT_STEP_RST;
            cfg_reg.repeat_frames   <= pdir_pkg::REPEAT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (pdir_pkg::reg_idx_t'(cfg_idx))
                pdir_pkg::REG_HEADER_MARK:
                    cfg_reg.header_mark_us <= cfg_wdata[pdir_pkg::SEG_W-1:0];
                pdir_pkg::REG_HEADER_SPACE:
                    cfg_reg.header_space_us <= cfg_wdata[pdir_pkg::SEG_W-1:0];
                pdir_pkg::REG_BIT_MARK:
                    cfg_reg.bit_mark_us <= cfg_wdata[pdir_pkg::SEG_W-1:0];
                pdir_pkg::REG_ONE_SPACE:
                    cfg_reg.one_space_us <= cfg_wdata[pdir_pkg::SEG_W-1:0];
                pdir_pkg::REG_ZERO_SPACE:
                    cfg_reg.zero_space_us <= cfg_wdata[pdir_pkg::SEG_W-1:0];
                pdir_pkg::REG_REPEAT_BASE:
                    cfg_reg.repeat_base_us <= cfg_wdata[pdir_pkg::SINCE_W-1:0];
                pdir_pkg::REG_REPEAT_STEP:
                    cfg_reg.repeat_step_us <= cfg_wdata[pdir_pkg::STEP_W-1:0];
                pdir_pkg::REG_REPEAT_COUNT:
                    cfg_reg.repeat_frames <= cfg_wdata[pdir_pkg::FRAMES_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

// ----- hw/rtl/pdir_frame_build.sv -----
// builds the frame, frame period and frame count for a send command
`timescale 1ns / 1ps
`default_nettype none
module pdir_frame_build (
    input  wire logic [1:0]  cmd,
    input  wire logic [3:0]  channel_nibble,
    input  wire logic [3:0]  mode_nibble,
    input  wire logic [3:0]  command_nibble,
    input  wire logic [15:0] raw_frame,
    input  wire logic        repeat_request,
    input  pdir_pkg::cfg_t   cfg,
    output pdir_pkg::load_t  load
);

    logic [pdir_pkg::RAW_W-1:0]   frame16;
    logic [3:0]                   parity;
    logic [1:0]                   chan;
    logic [pdir_pkg::SINCE_W-1:0] step_sum;
    logic [pdir_pkg::SINCE_W:0]   period_full;
    logic [pdir_pkg::FRAMES_W-1:0] nframes;

    always_comb
    begin
        parity = 4'hF ^ channel_nibble ^ mode_nibble ^ command_nibble;
        if (pdir_pkg::cmd_t'(cmd) == pdir_pkg::CMD_NIBBLE)
        begin
            frame16 = {channel_nibble, mode_nibble, command_nibble, parity};
        end
        else
        begin
            frame16 = raw_frame;
        end

        // channel picks the start-to-start period, saturating
        chan        = frame16[13:12];
        step_sum    = pdir_pkg::SINCE_W'(chan) * pdir_pkg::SINCE_W'(cfg.repeat_step_us);
        period_full = {1'b0, cfg.repeat_base_us} + {1'b0, step_sum};

        nframes = repeat_request ? cfg.repeat_frames : pdir_pkg::FRAMES_W'(1);

        load.frame  = pdir_pkg::fit_frame(frame16);
        load.period = period_full[pdir_pkg::SINCE_W] ? pdir_pkg::SINCE_MAX
                                                     : period_full[pdir_pkg::SINCE_W-1:0];
        load.frames = (nframes == '0) ? pdir_pkg::FRAMES_W'(1) : nframes;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/pdir_seq.sv -----
// frame sequencer with the result register
`timescale 1ns / 1ps
`default_nettype none
module pdir_seq (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic [1:0]  cmd,
    input  pdir_pkg::load_t  load,
    input  pdir_pkg::cfg_t   cfg,
    input  wire logic        out_ready,
    output logic             out_valid,
    output logic             ir_on,
    output logic             busy_res,
    output logic             rejected
);

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HMARK  = 3'd1,
        PH_HSPACE = 3'd2,
        PH_BMARK  = 3'd3,
        PH_BSPACE = 3'd4,
        PH_STOP   = 3'd5,
        PH_GAP    = 3'd6
    } phase_t;

    localparam int FB = pdir_pkg::FRAME_BITS;
    localparam int BW = pdir_pkg::BITS_W;
    localparam int SW = pdir_pkg::SEG_W;
    localparam int TW = pdir_pkg::SINCE_W;
    localparam int NW = pdir_pkg::FRAMES_W;

    phase_t          phase_reg, phase_next;
    logic [FB-1:0]   shift_reg, shift_next;
    logic [BW-1:0]   bits_reg, bits_next;
    logic [SW-1:0]   seg_reg, seg_next;
    logic [TW-1:0]   since_reg, since_next;
    logic [TW-1:0]   period_reg, period_next;
    logic [NW-1:0]   frames_reg, frames_next;
    logic            out_valid_reg, out_valid_next;
    logic            ir_on_reg, ir_on_next;
    logic            busy_reg, busy_next;
    logic            rej_reg, rej_next;

    logic [SW-1:0]   seg_len;
    logic [SW-1:0]   seg_inc;
    logic [TW-1:0]   since_inc;
    logic [BW-1:0]   bits_dec;
    logic [NW-1:0]   frames_dec;
    logic            is_busy;

    always_comb
    begin
        unique case (phase_reg)
            PH_HMARK:  seg_len = cfg.header_mark_us;
            PH_HSPACE: seg_len = cfg.header_space_us;
            PH_BMARK:  seg_len = cfg.bit_mark_us;
            PH_BSPACE: seg_len = shift_reg[FB-1] ? cfg.one_space_us : cfg.zero_space_us;
            PH_STOP:   seg_len = cfg.bit_mark_us;
            default:   seg_len = '0;
        endcase
    end

    always_comb
    begin
        is_busy    = (phase_reg != PH_IDLE);
        seg_inc    = seg_reg + SW'(1);
        since_inc  = (since_reg < pdir_pkg::SINCE_MAX) ? since_reg + TW'(1) : since_reg;
        bits_dec   = (bits_reg != '0) ? bits_reg - BW'(1) : '0;
        frames_dec = (frames_reg != '0) ? frames_reg - NW'(1) : '0;

        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_next      = bits_reg;
        seg_next       = seg_reg;
        since_next     = since_reg;
        period_next    = period_reg;
        frames_next    = frames_reg;
        out_valid_next = out_valid_reg && !out_ready;
        ir_on_next     = ir_on_reg;
        busy_next      = busy_reg;
        rej_next       = rej_reg;

        if (accept)
        begin
            out_valid_next = 1'b1;
            ir_on_next     = 1'b0;
            busy_next      = is_busy;
            rej_next       = 1'b0;
            case (pdir_pkg::cmd_t'(cmd)) inside
                pdir_pkg::CMD_TICK:
                begin
                    ir_on_next = (phase_reg == PH_HMARK) || (phase_reg == PH_BMARK)
                                 || (phase_reg == PH_STOP);
                    if (is_busy)
                    begin
                        since_next = since_inc;
                        if (phase_reg == PH_GAP)
                        begin
                            if (since_inc >= period_reg)
                            begin
                                phase_next = PH_HMARK;
                                seg_next   = '0;
                                since_next = '0;
                                bits_next  = BW'(FB);
                            end
                        end
                        else if (seg_inc < seg_len)
                        begin
                            seg_next = seg_inc;
                        end
                        else
                        begin
                            seg_next = '0;
                            unique case (phase_reg)
                                PH_HMARK:  phase_next = PH_HSPACE;
                                PH_HSPACE: phase_next = PH_BMARK;
                                PH_BMARK:  phase_next = PH_BSPACE;
                                PH_BSPACE:
                                begin
                                    shift_next = {shift_reg[FB-2:0], shift_reg[FB-1]};
                                    bits_next  = bits_dec;
                                    phase_next = (bits_dec != '0) ? PH_BMARK : PH_STOP;
                                end
                                default:
                                begin
                                    frames_next = frames_dec;
                                    if (frames_dec == '0)
                                    begin
                                        phase_next = PH_IDLE;
                                    end
                                    else if (since_inc >= period_reg)
                                    begin
                                        phase_next = PH_HMARK;
                                        since_next = '0;
                                        bits_next  = BW'(FB);
                                    end
                                    else
                                    begin
                                        phase_next = PH_GAP;
                                    end
                                end
                            endcase
                        end
                    end
                end
                pdir_pkg::CMD_NIBBLE, pdir_pkg::CMD_RAW:
                begin
                    busy_next = 1'b1;
                    if (is_busy)
                    begin
                        rej_next = 1'b1;
                    end
                    else
                    begin
                        period_next = load.period;
                        frames_next = load.frames;
                        shift_next  = load.frame;
                        phase_next  = PH_HMARK;
                        seg_next    = '0;
                        since_next  = '0;
                        bits_next   = BW'(FB);
                    end
                end
                default:
                begin
                    busy_next = is_busy;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            bits_reg      <= '0;
            seg_reg       <= '0;
            since_reg     <= '0;
            period_reg    <= '0;
            frames_reg    <= '0;
            out_valid_reg <= 1'b0;
            ir_on_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            rej_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            shift_reg     <= shift_next;
            bits_reg      <= bits_next;
            seg_reg       <= seg_next;
            since_reg     <= since_next;
            period_reg    <= period_next;
            frames_reg    <= frames_next;
            out_valid_reg <= out_valid_next;
            ir_on_reg     <= ir_on_next;
            busy_reg      <= busy_next;
            rej_reg       <= rej_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign ir_on     = ir_on_reg;
    assign busy_res  = busy_reg;
    assign rejected  = rej_reg;

endmodule
`default_nettype wire
